FILE: design/fcs_pkg.sv
// Package for the face cull and shade block: widths, register indexes,
// shade codes and the record that travels along the row of compare cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcs_pkg;

  localparam int CoordW    = 16;              // coordinates, normals, camera
  localparam int ProdW     = 2 * CoordW;      // full products and sums
  localparam int HW        = CoordW - 1;      // upper half of a non-negative dot
  localparam int HSqW      = 2 * HW;          // its square
  localparam int ShadeW    = 5;
  localparam int ShadeMagW = 4;
  localparam int NumCells  = 15;              // one cell per shade step
  localparam int CfgIdxW   = 2;

  localparam logic [ShadeW-1:0] SHADE_BACK = 5'h1F;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAMERA_X = 2'd0,
    CFG_CAMERA_Y = 2'd1,
    CFG_CAMERA_Z = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                 cull;
    logic [HSqW-1:0]      hsq;
    logic [CoordW-1:0]    s;
    logic [ShadeMagW-1:0] shade;
  } cell_data_t;

endpackage

`default_nettype wire

FILE: design/fcs_face_if.sv
// Channel that carries one face (normal and first vertex) into the block.
// Depends on fcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fcs_face_if;
  import fcs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] normal_x;
  logic signed [CoordW-1:0] normal_y;
  logic signed [CoordW-1:0] normal_z;
  logic signed [CoordW-1:0] point_x;
  logic signed [CoordW-1:0] point_y;
  logic signed [CoordW-1:0] point_z;

  modport source (output valid, normal_x, normal_y, normal_z, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, point_x, point_y, point_z,
                  output ready);
endinterface

`default_nettype wire

FILE: design/fcs_shade_if.sv
// Channel that carries one shade result out of the block.
// Depends on fcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fcs_shade_if;
  import fcs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ShadeW-1:0] shade;

  modport source (output valid, shade, input ready);
  modport sink   (input valid, shade, output ready);
endinterface

`default_nettype wire

FILE: design/face_cull_and_shade.sv
// Top level of the face cull and shade block: camera registers, front end
// and the row of compare cells. Depends on fcs_pkg, fcs_face_if,
// fcs_shade_if, fcs_front and fcs_cell.
//
// Usage: faces arrive on face_i (normal and first vertex), one transfer per
// face; each face gives exactly one transfer on shade_o, in order. The shade
// is -1 for a back-facing face, otherwise floor(sqrt(h*h/s)) limited to 15.
// The camera position is written through cfg_we_i, cfg_idx_i and cfg_data_i
// (x, y, z at indexes 0 to 2, higher indexes ignored) while no face is in
// flight.
// From the input transfer to its result on shade_o, a face passes through
// three front-end stages (products, sums, square of the dot's upper half)
// and one stage for each of the fifteen compare cells.
// Throughput is one face per cycle; every stage holds its own item, so a
// new face is taken whenever any stage downstream can move.
// When the receiver stalls, the last cell holds its result and stages fill
// up behind it; face_i.ready falls only once every stage is occupied.
// Reset clears all stages and sets the camera to the origin.
`timescale 1ns / 1ps
`default_nettype none

module face_cull_and_shade (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fcs_face_if.sink                      face_i,
  fcs_shade_if.source                   shade_o,
  input  logic                          cfg_we_i,
  input  logic [fcs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fcs_pkg::CoordW-1:0]    cfg_data_i
);
  import fcs_pkg::*;

  logic signed [CoordW-1:0] camera_x_q, camera_y_q, camera_z_q;

  logic [NumCells:0]        chain_valid;
  logic [NumCells:0]        chain_ready;
  cell_data_t               chain_data [NumCells+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera_x_q <= '0;
      camera_y_q <= '0;
      camera_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CAMERA_X: camera_x_q <= cfg_data_i;
        CFG_CAMERA_Y: camera_y_q <= cfg_data_i;
        CFG_CAMERA_Z: camera_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fcs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .face_i      (face_i),
    .camera_x_i  (camera_x_q),
    .camera_y_i  (camera_y_q),
    .camera_z_i  (camera_z_q),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_data_o  (chain_data[0])
  );

  for (genvar k = 1; k <= NumCells; k++) begin : g_cell
    fcs_cell #(.K(k)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k-1]),
      .in_ready_o  (chain_ready[k-1]),
      .in_data_i   (chain_data[k-1]),
      .out_valid_o (chain_valid[k]),
      .out_ready_i (chain_ready[k]),
      .out_data_o  (chain_data[k])
    );
  end

  assign chain_ready[NumCells] = shade_o.ready;
  assign shade_o.valid         = chain_valid[NumCells];
  assign shade_o.shade         = chain_data[NumCells].cull ? SHADE_BACK
                                 : {1'b0, chain_data[NumCells].shade};

`ifndef NO_ASSERTIONS
  // The input may only be held off when the whole row is full and stalled.
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !face_i.ready |-> shade_o.valid && !shade_o.ready)
    else $error("input refused while the pipeline can still move");

  // A zero squared length passes every cell and so reaches full brightness.
  a_zero_length_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[NumCells] && !chain_data[NumCells].cull && chain_data[NumCells].s == '0
    |-> chain_data[NumCells].shade == ShadeMagW'(NumCells))
    else $error("zero squared length did not give full shade");

  // Nothing leaves the block straight after reset.
  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !shade_o.valid)
    else $error("result presented straight after reset");
`endif

endmodule

`default_nettype wire

FILE: design/fcs_front.sv
// Front end: view vector, dot product, squared length and the square of the
// upper half of the dot, over three register stages.
// Depends on fcs_pkg and fcs_face_if.
`timescale 1ns / 1ps
`default_nettype none

module fcs_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fcs_face_if.sink                         face_i,
  input  logic signed [fcs_pkg::CoordW-1:0] camera_x_i,
  input  logic signed [fcs_pkg::CoordW-1:0] camera_y_i,
  input  logic signed [fcs_pkg::CoordW-1:0] camera_z_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output fcs_pkg::cell_data_t              out_data_o
);
  import fcs_pkg::*;

  logic                    s1_valid_q, s2_valid_q, s3_valid_q;
  logic                    s1_ready, s2_ready, s3_ready;

  logic signed [CoordW-1:0] view_x, view_y, view_z;
  logic signed [ProdW-1:0]  dot_x_q, dot_y_q, dot_z_q;
  logic signed [ProdW-1:0]  sq_x_q, sq_y_q, sq_z_q;
  logic signed [ProdW-1:0]  dot_sum;
  logic [ProdW-1:0]         sq_sum;
  logic                     cull_q2, cull_q3;
  logic [HW-1:0]            h_q;
  logic [CoordW-1:0]        s_q2, s_q3;
  logic [HSqW-1:0]          hsq_q;

  assign s3_ready     = !s3_valid_q || out_ready_i;
  assign s2_ready     = !s2_valid_q || s3_ready;
  assign s1_ready     = !s1_valid_q || s2_ready;
  assign face_i.ready = s1_ready;

  // The view vector wraps at 16 bits.
  assign view_x = camera_x_i - face_i.point_x;
  assign view_y = camera_y_i - face_i.point_y;
  assign view_z = camera_z_i - face_i.point_z;

  assign dot_sum = dot_x_q + dot_y_q + dot_z_q;
  assign sq_sum  = $unsigned(sq_x_q) + $unsigned(sq_y_q) + $unsigned(sq_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= face_i.valid;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && face_i.valid) begin
      dot_x_q <= face_i.normal_x * view_x;
      dot_y_q <= face_i.normal_y * view_y;
      dot_z_q <= face_i.normal_z * view_z;
      sq_x_q  <= view_x * view_x;
      sq_y_q  <= view_y * view_y;
      sq_z_q  <= view_z * view_z;
    end
    if (s2_ready && s1_valid_q) begin
      cull_q2 <= dot_sum[ProdW-1];
      h_q     <= dot_sum[ProdW-2:CoordW];
      s_q2    <= sq_sum[ProdW-1:CoordW];
    end
    if (s3_ready && s2_valid_q) begin
      cull_q3 <= cull_q2;
      hsq_q   <= h_q * h_q;
      s_q3    <= s_q2;
    end
  end

  assign out_valid_o      = s3_valid_q;
  assign out_data_o.cull  = cull_q3;
  assign out_data_o.hsq   = hsq_q;
  assign out_data_o.s     = s_q3;
  assign out_data_o.shade = '0;

endmodule

`default_nettype wire

FILE: design/fcs_cell.sv
// One compare cell: raises the running shade to K when K*K*s <= h*h, which
// is the same as K <= floor(sqrt(h*h / s)). Depends on fcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcs_cell #(
  parameter int K = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fcs_pkg::cell_data_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fcs_pkg::cell_data_t out_data_o
);
  import fcs_pkg::*;

  localparam logic [7:0] KSq = 8'(K * K);

  logic                      valid_q;
  cell_data_t                data_q, data_d;
  logic [CoordW+7:0]         limit;
  logic                      pass;

  assign limit = KSq * in_data_i.s;
  assign pass  = {{(HSqW-CoordW-8){1'b0}}, limit} <= in_data_i.hsq;

  always_comb begin
    data_d = in_data_i;
    if (pass) data_d.shade = ShadeMagW'(K);
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: dv/fcs_shade_checker.sv
// Checker for the face cull and shade block: follows the camera register
// writes, predicts the shade of every face transfer and compares it with the
// shade transfers in order. Depends on fcs_pkg, fcs_face_if and fcs_shade_if.
`timescale 1ns / 1ps

module fcs_shade_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  fcs_face_if                         face_i,
  fcs_shade_if                        shade_i,
  input  logic                        cfg_we_i,
  input  logic [fcs_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fcs_pkg::CoordW-1:0]  cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import fcs_pkg::*;

  localparam logic [ShadeW-1:0] ShadeFull  = 5'd15;
  localparam int                RatioLimit = 256;

  logic signed [CoordW-1:0] cam_x, cam_y, cam_z;
  logic [ShadeW-1:0]        shade_queue[$];
  logic [ShadeW-1:0]        expected;

  function automatic logic [ShadeW-1:0] predict_shade(
    input logic signed [CoordW-1:0] nx, ny, nz, ptx, pty, ptz);
    logic signed [CoordW-1:0] vx, vy, vz;
    logic signed [ProdW-1:0]  dot, len_sq;
    logic [ProdW-1:0]         hi_dot, hi_len, ratio;
    int                       root;
    // The view vector wraps at 16 bits; the sums wrap at 32 bits.
    vx  = cam_x - ptx;
    vy  = cam_y - pty;
    vz  = cam_z - ptz;
    dot = nx * vx + ny * vy + nz * vz;
    if (dot[ProdW-1]) return SHADE_BACK;
    len_sq = vx * vx + vy * vy + vz * vz;
    hi_dot = {{CoordW{1'b0}}, dot[ProdW-1:CoordW]};
    hi_len = {{CoordW{1'b0}}, len_sq[ProdW-1:CoordW]};
    if (hi_len == 0) return ShadeFull;
    ratio = (hi_dot * hi_dot) / hi_len;
    if (ratio >= RatioLimit) return ShadeFull;
    root = 0;
    while (root < int'(ShadeFull) && (root + 1) * (root + 1) <= ratio) root++;
    return ShadeW'(root);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x        <= '0;
      cam_y        <= '0;
      cam_z        <= '0;
      shade_queue.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CAMERA_X: cam_x <= cfg_data_i;
          CFG_CAMERA_Y: cam_y <= cfg_data_i;
          CFG_CAMERA_Z: cam_z <= cfg_data_i;
          default: ;
        endcase
      end
      if (face_i.valid && face_i.ready) begin
        shade_queue.push_back(predict_shade(face_i.normal_x, face_i.normal_y,
                                            face_i.normal_z, face_i.point_x,
                                            face_i.point_y, face_i.point_z));
      end
      if (shade_i.valid && shade_i.ready) begin
        if (shade_queue.size() == 0) begin
          $display("%0t: shade transfer with none expected, expected none, got %0d",
                   $time, $signed(shade_i.shade));
          fail_count_o <= fail_count_o + 1;
        end else begin
          expected = shade_queue.pop_front();
          if (shade_i.shade !== expected) begin
            $display("%0t: shade mismatch, expected %0d, got %0d",
                     $time, $signed(expected), $signed(shade_i.shade));
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= shade_queue.size();
    end
  end

endmodule

FILE: dv/testbench.sv
// Top of the face cull and shade testbench: clock, reset, camera writes,
// face and shade traffic with random idling, a watchdog and the verdict.
// Depends on fcs_pkg, the two channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module testbench;
  import fcs_pkg::*;

  localparam int HoldCycles  = 80;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 40;
  localparam int PhaseItems  = 250;
  localparam int NumPhases   = 7;
  localparam int IdlePct     = 38;

  localparam logic [CfgIdxW-1:0]       CfgIdxSpare = 2'd3;
  localparam logic signed [CoordW-1:0] CoordMax    = 16'sh7FFF;
  localparam logic signed [CoordW-1:0] CoordMin    = 16'sh8000;

  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               cfg_we   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx  = '0;
  logic [CoordW-1:0]  cfg_data = '0;

  int src_idle_pct  = IdlePct;
  int sink_idle_pct = IdlePct;
  int hold_reqs     = 0;
  int holds_done    = 0;
  int idle_cycles   = 0;
  int fail_count;
  int pending;

  // Our own copy of the camera, used only to aim faces close to it.
  logic signed [CoordW-1:0] cam[3] = '{16'sd0, 16'sd0, 16'sd0};

  fcs_face_if  face_ch ();
  fcs_shade_if shade_ch ();

  face_cull_and_shade dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .face_i     (face_ch),
    .shade_o    (shade_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  fcs_shade_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .face_i       (face_ch),
    .shade_i      (shade_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus long hold-offs on request.
  initial begin
    shade_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        shade_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        holds_done++;
      end else begin
        shade_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((face_ch.valid && face_ch.ready) || (shade_ch.valid && shade_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic set_camera(input logic signed [CoordW-1:0] x, y, z, input bit spare);
    write_reg(CFG_CAMERA_X, x);
    write_reg(CFG_CAMERA_Y, y);
    write_reg(CFG_CAMERA_Z, z);
    if (spare) write_reg(CfgIdxSpare, CoordW'($urandom));
    cfg_we <= 1'b0;
    cam[0] = x;
    cam[1] = y;
    cam[2] = z;
  endtask

  // Called and left at a falling edge; one transfer per call.
  task automatic send_face(input logic signed [CoordW-1:0] nx, ny, nz, px, py, pz);
    while ($urandom_range(99) < src_idle_pct) begin
      face_ch.valid <= 1'b0;
      @(negedge clk);
    end
    face_ch.valid    <= 1'b1;
    face_ch.normal_x <= nx;
    face_ch.normal_y <= ny;
    face_ch.normal_z <= nz;
    face_ch.point_x  <= px;
    face_ch.point_y  <= py;
    face_ch.point_z  <= pz;
    do @(posedge clk); while (!face_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_random_face();
    logic signed [CoordW-1:0] n[3];
    logic signed [CoordW-1:0] p[3];
    int                       kind;
    int                       shift;
    kind  = $urandom_range(99);
    shift = $urandom_range(12);
    for (int i = 0; i < 3; i++) begin
      n[i] = CoordW'($urandom);
      p[i] = CoordW'($urandom);
    end
    if (kind < 35) begin
      // Scaled-down normals spread the shade over its whole range.
      shift = $urandom_range(10, 3);
      for (int i = 0; i < 3; i++) n[i] = n[i] >>> shift;
    end else if (kind < 55) begin
      // Vertices near the camera give short view vectors and zero lengths.
      for (int i = 0; i < 3; i++) begin
        p[i] = cam[i] + CoordW'($urandom_range(511) - 256);
        n[i] = n[i] >>> shift;
      end
    end
    send_face(n[0], n[1], n[2], p[0], p[1], p[2]);
  endtask

  task automatic wait_for_results();
    face_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    face_ch.valid    = 1'b0;
    face_ch.normal_x = '0;
    face_ch.normal_y = '0;
    face_ch.normal_z = '0;
    face_ch.point_x  = '0;
    face_ch.point_y  = '0;
    face_ch.point_z  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed faces with the camera at the origin.
    set_camera(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_face(0, 0, 0, 0, 0, 0);
    send_face(1, 0, 0, -16384, 0, 0);
    send_face(1024, 0, 0, -16384, 0, 0);
    send_face(2304, 0, 0, -16384, 0, 0);
    send_face(3840, 0, 0, -16384, 0, 0);
    send_face(4096, 0, 0, -16384, 0, 0);
    send_face(-1, 0, 0, -16384, 0, 0);
    send_face(0, 0, -2304, 0, 0, 16384);
    send_face(0, -2560, 0, 0, 16384, 0);
    send_face(0, 100, 0, -16384, 0, 0);
    send_face(1000, 0, 0, -1, 0, 0);
    send_face(-1000, 0, 0, -1, 0, 0);
    send_face(CoordMin, CoordMin, CoordMin, CoordMin, CoordMin, CoordMin);
    send_face(CoordMax, CoordMax, CoordMax, -CoordMax, -CoordMax, -CoordMax);
    send_face(CoordMin, CoordMin, 0, CoordMin, CoordMin, 0);
    send_face(CoordMin, 0, 0, CoordMax, 0, 0);
    send_face(0, 0, 0, CoordMin, CoordMin, CoordMin);
    send_face(-1, -1, -1, CoordMin, CoordMin, CoordMin);
    send_face(CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
    wait_for_results();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: set_camera(CoordMax, CoordMax, CoordMax, 1'b0);
        1: set_camera(CoordMin, CoordMin, CoordMin, 1'b1);
        3: set_camera(CoordMax, CoordMin, 16'sd0, 1'b1);
        default: set_camera(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
                            1'(phase));
      endcase
      if (phase == 2) begin
        // Keep offering faces while the receiver holds off, so the block fills.
        src_idle_pct = 0;
        hold_reqs++;
      end else if (phase == 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = IdlePct;
        sink_idle_pct = IdlePct;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        if (phase == 2 && i == 60) src_idle_pct = IdlePct;
        send_random_face();
      end
      wait_for_results();
    end

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: face_cull_and_shade.f
design/fcs_pkg.sv
design/fcs_face_if.sv
design/fcs_shade_if.sv
design/fcs_front.sv
design/fcs_cell.sv
design/face_cull_and_shade.sv
dv/fcs_shade_checker.sv
dv/testbench.sv
